[sv/lrr_pkg.sv]
// Package for the revolution reassembler: result status codes, command codes,
// the result record and default sizes. No dependencies.
`default_nettype none

package lrr_pkg;

    // Default sizing, handed to the top-level parameters
    localparam int MAX_POINTS_DEF        = 4096;
    localparam int MAX_PACKET_POINTS_DEF = 210;

    // Fixed field widths
    localparam int REV_W   = 8;
    localparam int TOTAL_W = 16;
    localparam int COUNT_W = 8;
    localparam int START_W = 16;
    localparam int DIST_W  = 16;
    localparam int IDX_W   = 12;
    // Width used for compares of point positions against 16-bit header fields
    localparam int CMP_W   = 17;

    // Request kind
    localparam logic CMD_HEADER = 1'b0;
    localparam logic CMD_POINT  = 1'b1;

    typedef enum logic [2:0] {
        ST_IGNORED  = 3'd0,
        ST_HEADER   = 3'd1,
        ST_STORED   = 3'd2,
        ST_COMPLETE = 3'd3,
        ST_MISSED   = 3'd4,
        ST_OVERFLOW = 3'd5
    } status_t;

    typedef struct packed {
        status_t              status;
        logic [IDX_W-1:0]     store_index;
        logic [DIST_W-1:0]    stored_distance;
        logic [IDX_W-1:0]     gathered_count;
    } lrr_result_t;

endpackage

`default_nettype wire

[sv/lrr_in_if.sv]
// Input channel of the revolution reassembler: valid/ready plus header/point fields.
// Depends on nothing.
`default_nettype none

interface lrr_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [7:0]  revolution_index;
    logic [15:0] point_total;
    logic [7:0]  point_count;
    logic [15:0] start_index;
    logic [15:0] distance_cm;

    modport source (
        output valid, command, revolution_index, point_total, point_count,
               start_index, distance_cm,
        input  ready
    );
    modport sink (
        input  valid, command, revolution_index, point_total, point_count,
               start_index, distance_cm,
        output ready
    );
endinterface

`default_nettype wire

[sv/lrr_out_if.sv]
// Result channel of the revolution reassembler: valid/ready plus result fields.
// Depends on lrr_pkg for the status type.
`default_nettype none

interface lrr_out_if;
    logic            valid;
    logic            ready;
    lrr_pkg::status_t status;
    logic [11:0]     store_index;
    logic [15:0]     stored_distance;
    logic [11:0]     gathered_count;

    modport source (
        output valid, status, store_index, stored_distance, gathered_count,
        input  ready
    );
    modport sink (
        input  valid, status, store_index, stored_distance, gathered_count,
        output ready
    );
endinterface

`default_nettype wire

[sv/lrr_core.sv]
// Gather state and per-request decision logic of the revolution reassembler.
// Depends on lrr_pkg.
`default_nettype none

module lrr_core #(
    parameter int MAX_POINTS        = lrr_pkg::MAX_POINTS_DEF,
    parameter int MAX_PACKET_POINTS = lrr_pkg::MAX_PACKET_POINTS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic                        command,
    input  wire logic [lrr_pkg::REV_W-1:0]   revolution_index,
    input  wire logic [lrr_pkg::TOTAL_W-1:0] point_total,
    input  wire logic [lrr_pkg::COUNT_W-1:0] point_count,
    input  wire logic [lrr_pkg::START_W-1:0] start_index,
    input  wire logic [lrr_pkg::DIST_W-1:0]  distance_cm,
    output lrr_pkg::lrr_result_t             result
);
    import lrr_pkg::*;

    // Gathered count never reaches MAX_POINTS
    localparam int GW = $clog2(MAX_POINTS);

    logic                gathering_reg, gathering_next;
    logic [REV_W-1:0]    cur_rev_reg, cur_rev_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [GW-1:0]       gathered_reg, gathered_next;
    logic [COUNT_W-1:0]  left_reg, left_next;

    // Effective gather context for a header (a starting header opens a fresh one)
    logic [REV_W-1:0]    eff_rev;
    logic [TOTAL_W-1:0]  eff_total;
    logic [GW-1:0]       eff_gathered;
    logic [GW-1:0]       gathered_inc;
    logic [COUNT_W-1:0]  left_dec;
    logic                hdr_mismatch;
    logic                hdr_overflow;
    logic                hdr_empty_done;
    logic                pt_done;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gathering_reg <= 1'b0;
            cur_rev_reg   <= '0;
            total_reg     <= '0;
            gathered_reg  <= '0;
            left_reg      <= '0;
        end
        else if (accept)
        begin
            gathering_reg <= gathering_next;
            cur_rev_reg   <= cur_rev_next;
            total_reg     <= total_next;
            gathered_reg  <= gathered_next;
            left_reg      <= left_next;
        end
    end

    // Header checks
    always_comb
    begin
        eff_rev      = gathering_reg ? cur_rev_reg  : revolution_index;
        eff_total    = gathering_reg ? total_reg    : point_total;
        eff_gathered = gathering_reg ? gathered_reg : '0;
        hdr_mismatch = (revolution_index != eff_rev)
                    || ({1'b0, start_index} != CMP_W'(eff_gathered));
        hdr_overflow = (point_count > COUNT_W'(MAX_PACKET_POINTS))
                    || ((CMP_W'(eff_gathered) + CMP_W'(point_count)) >= CMP_W'(MAX_POINTS));
        hdr_empty_done = (point_count == '0)
                      && (CMP_W'(eff_gathered) == CMP_W'(eff_total));
    end

    // Point bookkeeping
    assign gathered_inc = gathered_reg + GW'(1);
    assign left_dec     = left_reg - COUNT_W'(1);
    assign pt_done      = (left_dec == '0) && (CMP_W'(gathered_inc) == CMP_W'(total_reg));

    // Next state and result
    always_comb
    begin
        gathering_next = gathering_reg;
        cur_rev_next   = cur_rev_reg;
        total_next     = total_reg;
        gathered_next  = gathered_reg;
        left_next      = left_reg;
        result.status          = ST_IGNORED;
        result.store_index     = '0;
        result.stored_distance = '0;

        case (command)
            CMD_HEADER:
            begin
                left_next = '0;
                if (gathering_reg || (start_index == '0))
                begin
                    gathering_next = 1'b1;
                    cur_rev_next   = eff_rev;
                    total_next     = eff_total;
                    gathered_next  = eff_gathered;
                    if (hdr_mismatch)
                    begin
                        gathering_next = 1'b0;
                        result.status  = ST_MISSED;
                    end
                    else if (hdr_overflow)
                    begin
                        gathering_next = 1'b0;
                        result.status  = ST_OVERFLOW;
                    end
                    else
                    begin
                        left_next = point_count;
                        if (hdr_empty_done)
                        begin
                            gathering_next = 1'b0;
                            result.status  = ST_COMPLETE;
                        end
                        else
                        begin
                            result.status = ST_HEADER;
                        end
                    end
                end
            end
            CMD_POINT:
            begin
                if (gathering_reg && (left_reg != '0))
                begin
                    gathered_next          = gathered_inc;
                    left_next              = left_dec;
                    result.store_index     = IDX_W'(gathered_reg);
                    result.stored_distance = distance_cm;
                    if (pt_done)
                    begin
                        gathering_next = 1'b0;
                        result.status  = ST_COMPLETE;
                    end
                    else
                    begin
                        result.status = ST_STORED;
                    end
                end
            end
            default:
            begin
                result.status = ST_IGNORED;
            end
        endcase

        result.gathered_count = IDX_W'(gathered_next);
    end

endmodule

`default_nettype wire

[sv/lidar_revolution_reassembler_unit.sv]
// Top level of the scanner revolution reassembler: handshake and result register.
// Depends on lrr_pkg, lrr_in_if, lrr_out_if and lrr_core.
//
// Usage:
//   in_ch carries requests: a header (command 0) announces a packet with its
//   revolution number, revolution total, point count and start index; a point
//   (command 1) carries one distance in cm. out_ch returns exactly one result
//   per request: a status code, a buffer write (store_index, stored_distance)
//   for stored points, and the running gathered count.
//   Latency: the result is valid on the cycle after the request is accepted.
//   Throughput: one request per cycle while the receiver keeps taking results;
//   the gather state is updated by a single pass of compare/add logic at
//   acceptance, and the result lands in one output register.
//   When the receiver stalls, the output register holds its result and
//   in_ch.ready drops until out_ch.ready returns; a new request is taken in the
//   same cycle that the held result is taken.
//   Reset (rst_n low, asynchronous) clears the gather: the block waits for a
//   header with start index 0, and no result is pending.
`default_nettype none

module lidar_revolution_reassembler_unit #(
    parameter int MAX_POINTS        = lrr_pkg::MAX_POINTS_DEF,
    parameter int MAX_PACKET_POINTS = lrr_pkg::MAX_PACKET_POINTS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lrr_in_if.sink     in_ch,
    lrr_out_if.source  out_ch
);
    import lrr_pkg::*;

    logic        accept;
    lrr_result_t step_result;
    lrr_result_t result_reg;
    logic        out_valid_reg;

    // Take a request whenever the output register is free or being drained
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    lrr_core #(
        .MAX_POINTS        (MAX_POINTS),
        .MAX_PACKET_POINTS (MAX_PACKET_POINTS)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .command          (in_ch.command),
        .revolution_index (in_ch.revolution_index),
        .point_total      (in_ch.point_total),
        .point_count      (in_ch.point_count),
        .start_index      (in_ch.start_index),
        .distance_cm      (in_ch.distance_cm),
        .result           (step_result)
    );

    // Output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            out_valid_reg <= in_ch.valid;
        end
    end

    // Result payload register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= step_result;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.status          = result_reg.status;
    assign out_ch.store_index     = result_reg.store_index;
    assign out_ch.stored_distance = result_reg.stored_distance;
    assign out_ch.gathered_count  = result_reg.gathered_count;

endmodule

`default_nettype wire

[tb/lidar_revolution_reassembler_unit_tb.sv]
// Testbench for lidar_revolution_reassembler_unit: random and directed header/point
// traffic, predicted in-bench and checked result by result.
// Depends on lrr_pkg, lrr_in_if, lrr_out_if and the unit itself.
`timescale 1ns / 1ps

module lidar_revolution_reassembler_unit_tb;
    import lrr_pkg::*;

    localparam int MAX_POINTS        = MAX_POINTS_DEF;
    localparam int MAX_PACKET_POINTS = MAX_PACKET_POINTS_DEF;
    localparam int CYCLE_LIMIT       = 300000;
    localparam int DRAIN_CYCLES      = 4;

    // One request as it travels on in_ch
    typedef struct packed {
        logic               command;
        logic [REV_W-1:0]   rev;
        logic [TOTAL_W-1:0] total;
        logic [COUNT_W-1:0] count;
        logic [START_W-1:0] start;
        logic [DIST_W-1:0]  dist_cm;
    } lidar_request_t;

    // Ways a well-formed revolution gets broken
    typedef enum int {
        FAULT_NONE,
        FAULT_REV,
        FAULT_START,
        FAULT_SHORT,
        FAULT_EXTRA,
        FAULT_COUNT
    } fault_t;

    logic clk;
    logic rst_n;

    lrr_in_if  in_ch ();
    lrr_out_if out_ch ();

    lidar_revolution_reassembler_unit #(
        .MAX_POINTS        (MAX_POINTS),
        .MAX_PACKET_POINTS (MAX_PACKET_POINTS)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Gather state of the predictor
    logic               gather_open;
    logic [REV_W-1:0]   gather_rev;
    logic [TOTAL_W-1:0] gather_total;
    logic [IDX_W-1:0]   gather_count;
    logic [COUNT_W-1:0] packet_left;

    lidar_request_t request_queue[$];
    lrr_result_t    predicted_results[$];
    lidar_request_t on_wire;
    lrr_result_t    want;

    int queued_count   = 0;
    int accepted_count = 0;
    int error_count    = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Predicted result of one accepted request; advances the gather state
    function automatic lrr_result_t reassemble_step(input lidar_request_t rq);
        lrr_result_t res;
        res = '0;
        res.status = ST_IGNORED;
        if (rq.command == CMD_HEADER)
        begin
            packet_left = '0;
            if (gather_open || rq.start == '0)
            begin
                // a start-0 header while waiting opens a new gather
                if (!gather_open)
                begin
                    gather_open  = 1'b1;
                    gather_count = '0;
                    gather_total = rq.total;
                    gather_rev   = rq.rev;
                end
                if (rq.rev != gather_rev || rq.start != gather_count)
                begin
                    gather_open = 1'b0;
                    res.status  = ST_MISSED;
                end
                else if (int'(rq.count) > MAX_PACKET_POINTS ||
                         int'(gather_count) + int'(rq.count) >= MAX_POINTS)
                begin
                    gather_open = 1'b0;
                    res.status  = ST_OVERFLOW;
                end
                else
                begin
                    packet_left = rq.count;
                    // empty packet may finish the revolution right away
                    if (rq.count == '0 && gather_count == gather_total)
                    begin
                        gather_open = 1'b0;
                        res.status  = ST_COMPLETE;
                    end
                    else
                    begin
                        res.status = ST_HEADER;
                    end
                end
            end
        end
        else if (gather_open && packet_left != '0)
        begin
            res.status          = ST_STORED;
            res.store_index     = gather_count;
            res.stored_distance = rq.dist_cm;
            gather_count        = gather_count + 1'b1;
            packet_left         = packet_left - 1'b1;
            if (packet_left == '0 && gather_count == gather_total)
            begin
                gather_open = 1'b0;
                res.status  = ST_COMPLETE;
            end
        end
        res.gathered_count = gather_count;
        return res;
    endfunction

    task automatic queue_request(input lidar_request_t rq);
        request_queue.insert(request_queue.size(), rq);
        queued_count++;
    endtask

    // Header with a random (unused) distance field
    task automatic queue_header(input logic [REV_W-1:0] rev, input logic [TOTAL_W-1:0] total,
                                input logic [COUNT_W-1:0] count,
                                input logic [START_W-1:0] start);
        lidar_request_t rq;
        rq.command = CMD_HEADER;
        rq.rev     = rev;
        rq.total   = total;
        rq.count   = count;
        rq.start   = start;
        rq.dist_cm = DIST_W'($urandom_range(0, 65535));
        queue_request(rq);
    endtask

    // Point with random (unused) header fields
    task automatic queue_point(input logic [DIST_W-1:0] point_dist);
        lidar_request_t rq;
        rq.command = CMD_POINT;
        rq.rev     = REV_W'($urandom_range(0, 255));
        rq.total   = TOTAL_W'($urandom_range(0, 65535));
        rq.count   = COUNT_W'($urandom_range(0, 255));
        rq.start   = START_W'($urandom_range(0, 65535));
        rq.dist_cm = point_dist;
        queue_request(rq);
    endtask

    task automatic queue_noise();
        lidar_request_t rq;
        rq.command = 1'($urandom_range(0, 1));
        rq.rev     = REV_W'($urandom_range(0, 255));
        rq.total   = TOTAL_W'($urandom_range(0, 65535));
        rq.count   = COUNT_W'($urandom_range(0, 255));
        rq.start   = $urandom_range(0, 1) ? '0 : START_W'($urandom_range(0, 65535));
        rq.dist_cm = DIST_W'($urandom_range(0, 65535));
        queue_request(rq);
    endtask

    // A revolution of consecutive packets, occasionally broken somewhere
    task automatic queue_revolution();
        logic [REV_W-1:0]   rev;
        logic [TOTAL_W-1:0] total;
        int                 counts[$];
        int                 sum;
        int                 base;
        int                 npts;
        fault_t             fault;
        rev = REV_W'($urandom_range(0, 255));
        sum = 0;
        repeat ($urandom_range(1, 6))
        begin
            counts.insert(counts.size(),
                          ($urandom_range(0, 9) == 0) ? $urandom_range(100, MAX_PACKET_POINTS)
                                                      : $urandom_range(0, 12));
            sum += counts[$];
        end
        total = ($urandom_range(0, 9) == 0) ? TOTAL_W'($urandom_range(0, 65535))
                                            : TOTAL_W'(sum);
        base = 0;
        foreach (counts[i])
        begin
            fault = ($urandom_range(0, 19) == 0) ? fault_t'($urandom_range(1, 5)) : FAULT_NONE;
            case (fault)
                FAULT_REV:   queue_header(rev + 8'd1, total, COUNT_W'(counts[i]), START_W'(base));
                FAULT_START: queue_header(rev, total, COUNT_W'(counts[i]),
                                          START_W'(base + $urandom_range(1, 300)));
                FAULT_COUNT: queue_header(rev, total, COUNT_W'($urandom_range(211, 255)),
                                          START_W'(base));
                default:     queue_header(rev, total, COUNT_W'(counts[i]), START_W'(base));
            endcase
            npts = counts[i];
            if (fault == FAULT_SHORT && npts > 0)
                npts = $urandom_range(0, npts - 1);
            if (fault == FAULT_EXTRA)
                npts++;
            repeat (npts) queue_point(DIST_W'($urandom_range(0, 65535)));
            base += counts[i];
        end
    endtask

    task automatic queue_random(input int n);
        int target;
        target = queued_count + n;
        while (queued_count < target)
        begin
            if ($urandom_range(0, 99) < 75)
                queue_revolution();
            else
                queue_noise();
        end
    endtask

    task automatic queue_directed();
        queue_point(16'hFFFF);                           // stray point after reset
        queue_header(8'd255, 16'hFFFF, 8'd255, 16'hFFFF); // waiting, nonzero start
        queue_header(8'd0, 16'd0, 8'd0, 16'd0);            // empty revolution
        queue_header(8'd255, 16'd3, 8'd2, 16'd0);
        queue_point(16'hFFFF);
        queue_point(16'h0000);
        queue_point(16'h1234);                           // no points left
        queue_header(8'd255, 16'd3, 8'd1, 16'd2);
        queue_point(16'hA5A5);                           // completes on a point
        queue_header(8'd7, 16'd10, 8'd211, 16'd0);         // packet too large
        queue_header(8'd7, 16'd10, 8'd4, 16'd0);
        queue_point(16'd1234);
        queue_header(8'd7, 16'd10, 8'd2, 16'd4);           // header mid packet
        queue_point(16'h5A5A);                           // point while waiting
        queue_header(8'd9, 16'd5, 8'd2, 16'd0);
        queue_point(16'h8000);
        queue_point(16'h7FFF);
        queue_header(8'd8, 16'd5, 8'd3, 16'd2);            // wrong revolution
        queue_header(8'd9, 16'd4, 8'd0, 16'd0);            // empty, not complete
        queue_header(8'd9, 16'd4, 8'd1, 16'd3);            // wrong start
        queue_header(8'd1, 16'h8000, 8'd210, 16'd0);       // largest legal packet
        queue_header(8'd1, 16'h8000, 8'd255, 16'd0);       // largest count field
    endtask

    task automatic wait_drained();
        while (accepted_count != queued_count || predicted_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string what, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
            error_count++;
        end
    endtask

    // Stimulus and phase control
    initial
    begin
        rst_n                  = 1'b0;
        in_ch.valid            = 1'b0;
        in_ch.command          = CMD_HEADER;
        in_ch.revolution_index = '0;
        in_ch.point_total      = '0;
        in_ch.point_count      = '0;
        in_ch.start_index      = '0;
        in_ch.distance_cm      = '0;
        out_ch.ready           = 1'b0;
        gather_open            = 1'b0;
        gather_rev             = '0;
        gather_total           = '0;
        gather_count           = '0;
        packet_left            = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // sender idles less than the receiver
        send_idle_pct = 24;
        recv_idle_pct = 50;
        queue_directed();
        queue_random(530);
        wait_drained();

        // receiver idles less than the sender
        send_idle_pct = 50;
        recv_idle_pct = 24;
        queue_random(550);
        wait_drained();

        // full rate both ways
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(550);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Driver: predict on acceptance, then load the next request or idle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predicted_results.insert(predicted_results.size(), reassemble_step(on_wire));
                accepted_count++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    on_wire = request_queue.pop_front();
                    in_ch.valid            <= 1'b1;
                    in_ch.command          <= on_wire.command;
                    in_ch.revolution_index <= on_wire.rev;
                    in_ch.point_total      <= on_wire.total;
                    in_ch.point_count      <= on_wire.count;
                    in_ch.start_index      <= on_wire.start;
                    in_ch.distance_cm      <= on_wire.dist_cm;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each taken result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: result with none expected, got status %0d", $time,
                             out_ch.status);
                    error_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("status", 16'(want.status), 16'(out_ch.status));
                    check_field("store_index", 16'(want.store_index), 16'(out_ch.store_index));
                    check_field("stored_distance", want.stored_distance,
                                out_ch.stored_distance);
                    check_field("gathered_count", 16'(want.gathered_count),
                                16'(out_ch.gathered_count));
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule
